// ----- design/pcqs_pkg.sv -----
// Shared constants and types for the priority and custom queue scheduler.
package pcqs_pkg;

   localparam int NUM_QUEUES_DEFAULT  = 16;
   localparam int QUEUE_DEPTH_DEFAULT = 64;

   localparam logic [1:0]  MODE_FIFO     = 2'd0;
   localparam logic [1:0]  MODE_PRIORITY = 2'd1;
   localparam logic [1:0]  MODE_ROUND    = 2'd2;

   localparam logic [1:0]  STATUS_QUEUED   = 2'd0;
   localparam logic [1:0]  STATUS_DROPPED  = 2'd1;
   localparam logic [1:0]  STATUS_DEQUEUED = 2'd2;
   localparam logic [1:0]  STATUS_EMPTY    = 2'd3;

   localparam logic [2:0]  REG_MODE          = 3'd0;
   localparam logic [2:0]  REG_DEFAULT_QUEUE = 3'd1;
   localparam logic [2:0]  REG_HOLD_CAPACITY = 3'd2;
   localparam logic [2:0]  REG_QUEUE_LIMIT   = 3'd3;
   localparam logic [2:0]  REG_BYTE_QUANTUM  = 3'd4;

   localparam logic [1:0]  RESET_MODE          = 2'd0;
   localparam logic [3:0]  RESET_DEFAULT_QUEUE = 4'd0;
   localparam logic [10:0] RESET_HOLD_CAPACITY = 11'd75;
   localparam logic [6:0]  RESET_QUEUE_LIMIT   = 7'd20;
   localparam logic [15:0] RESET_BYTE_QUANTUM  = 16'd1500;

   localparam int PRIORITY_QUEUES = 4;
   localparam int CREDIT_WIDTH    = 17;
   localparam int WORD_WIDTH      = 30;

   typedef struct packed {
      logic [1:0]  mode;
      logic [3:0]  default_queue;
      logic [10:0] hold_capacity;
      logic [6:0]  queue_limit;
      logic [15:0] byte_quantum;
   } cfg_type;

endpackage

// ----- design/pcqs_store.sv -----
// Shared packet descriptor memory, one registered read per cycle plus a write when wr_en is high.
module pcqs_store #(
   parameter int ADDR_WIDTH = 10
) (
   input  logic                              clock,
   input  logic                              wr_en,
   input  logic [ADDR_WIDTH-1:0]             addr,
   input  logic [pcqs_pkg::WORD_WIDTH-1:0]   wr_data,
   output logic [pcqs_pkg::WORD_WIDTH-1:0]   rd_data
);

   logic [pcqs_pkg::WORD_WIDTH-1:0] mem [2**ADDR_WIDTH];
   logic [pcqs_pkg::WORD_WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data_ff <= mem[addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- design/priority_custom_queue_scheduler.sv -----
// Top level of the priority and custom queue scheduler.
// Takes one enqueue or dequeue request when start is high and busy is low, and
// answers each request with exactly one result held on the rsp_ ports for one
// cycle under rsp_valid; the receiver cannot stall it. An enqueue passes the
// decide state, which also writes the store, and then the answer state. A
// dequeue in FIFO or priority mode passes decide, read the store, pop and
// answer; in round-robin mode the sequencer examines one queue per cycle
// starting at the round-robin pointer and steps over empty queues before the
// read, pop and answer. A dequeue that returns nothing goes from decide
// straight to the answer. The single shared packet store port serves one
// access per request. Busy is high from acceptance until the result is shown.
// Configuration writes land at once and must only be made while idle.
module priority_custom_queue_scheduler #(
   parameter int NUM_QUEUES  = pcqs_pkg::NUM_QUEUES_DEFAULT,
   parameter int QUEUE_DEPTH = pcqs_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_kind,
   input  logic [4:0]  req_class_match,
   input  logic [13:0] req_pkt_len,
   input  logic [15:0] req_pkt_tag,
   output logic        rsp_valid,
   output logic [1:0]  rsp_status,
   output logic [15:0] rsp_out_tag,
   output logic [13:0] rsp_out_len,
   output logic [3:0]  rsp_out_queue,
   output logic [10:0] rsp_held_count,
   output logic [15:0] rsp_drop_count,
   input  logic        csr_write_enable,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_write_data
);

   localparam int QW = $clog2(NUM_QUEUES);
   localparam int DW = $clog2(QUEUE_DEPTH);
   localparam int CW = DW + 1;
   localparam int AW = QW + DW;
   localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_DEC   = 3'd1;
   localparam logic [2:0] ST_SCAN  = 3'd2;
   localparam logic [2:0] ST_READ  = 3'd3;
   localparam logic [2:0] ST_POP   = 3'd4;
   localparam logic [2:0] ST_RESP  = 3'd5;

   pcqs_pkg::cfg_type cfg_ff;

   logic [2:0]  state_ff, state_in;
   logic        kind_ff;
   logic [4:0]  cls_ff;
   logic [13:0] len_ff;
   logic [15:0] tag_ff;

   logic [DW-1:0] heads_ff [NUM_QUEUES];
   logic [CW-1:0] counts_ff [NUM_QUEUES];
   logic signed [pcqs_pkg::CREDIT_WIDTH-1:0] credit_ff [NUM_QUEUES];
   logic [QW-1:0] rr_ff;
   logic [10:0]   held_ff;
   logic [15:0]   drops_ff;

   logic [QW-1:0] q_ff;
   logic [QW:0]   scan_ff;
   logic [1:0]    status_ff;
   logic [15:0]   otag_ff;
   logic [13:0]   olen_ff;
   logic          valid_ff;

   logic          st_we;
   logic [AW-1:0] st_addr;
   logic [pcqs_pkg::WORD_WIDTH-1:0] st_rd;

   logic [QW-1:0] pick_q;
   logic [CW-1:0] limit;
   logic [1:0]    prio_q;
   logic          prio_found;
   logic signed [pcqs_pkg::CREDIT_WIDTH-1:0] new_credit;

   pcqs_store #(.ADDR_WIDTH(AW)) u_store (
      .clock   (clock),
      .wr_en   (st_we),
      .addr    (st_addr),
      .wr_data ({len_ff, tag_ff}),
      .rd_data (st_rd)
   );

   // Queue choice for an enqueue.
   always_comb begin
      pick_q = '0;
      if (cfg_ff.mode == pcqs_pkg::MODE_PRIORITY) begin
         pick_q = (cls_ff < 5'd4) ? QW'(cls_ff[1:0]) : QW'(cfg_ff.default_queue[1:0]);
      end else if (cfg_ff.mode == pcqs_pkg::MODE_ROUND) begin
         pick_q = (32'(cls_ff) < NUM_QUEUES) ? QW'(cls_ff) : QW'(cfg_ff.default_queue);
      end
      if (cfg_ff.mode == pcqs_pkg::MODE_PRIORITY || cfg_ff.mode == pcqs_pkg::MODE_ROUND) begin
         limit = (32'(cfg_ff.queue_limit) > QUEUE_DEPTH) ? DEPTH_C : CW'(cfg_ff.queue_limit);
      end else begin
         limit = DEPTH_C;
      end
   end

   // Highest priority non-empty queue among the first four.
   always_comb begin
      prio_found = 1'b0;
      prio_q     = 2'd0;
      for (int i = pcqs_pkg::PRIORITY_QUEUES - 1; i >= 0; i--) begin
         if (counts_ff[i] != '0) begin
            prio_found = 1'b1;
            prio_q     = 2'(i);
         end
      end
   end

   assign new_credit = credit_ff[q_ff] - $signed({3'b000, st_rd[29:16]});

   // The store address: enqueue writes at head + count, dequeue reads at head.
   always_comb begin
      st_we   = 1'b0;
      st_addr = {q_ff, heads_ff[q_ff]};
      if (state_ff == ST_DEC && !kind_ff) begin
         st_addr = {pick_q, DW'(heads_ff[pick_q] + counts_ff[pick_q][DW-1:0])};
         st_we   = (held_ff < cfg_ff.hold_capacity) && (counts_ff[pick_q] < limit);
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (start) state_in = ST_DEC;
         ST_DEC: begin
            if (!kind_ff || held_ff == '0) state_in = ST_RESP;
            else if (cfg_ff.mode == pcqs_pkg::MODE_ROUND) state_in = ST_SCAN;
            else if ((cfg_ff.mode == pcqs_pkg::MODE_PRIORITY && prio_found) ||
                     (cfg_ff.mode != pcqs_pkg::MODE_PRIORITY && counts_ff[0] != '0))
               state_in = ST_READ;
            else state_in = ST_RESP;
         end
         ST_SCAN: begin
            if (32'(scan_ff) == NUM_QUEUES) state_in = ST_RESP;
            else if (counts_ff[rr_ff] != '0) state_in = ST_READ;
         end
         ST_READ: state_in = ST_POP;
         ST_POP:  state_in = ST_RESP;
         ST_RESP: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cfg_ff   <= '{pcqs_pkg::RESET_MODE, pcqs_pkg::RESET_DEFAULT_QUEUE,
                       pcqs_pkg::RESET_HOLD_CAPACITY, pcqs_pkg::RESET_QUEUE_LIMIT,
                       pcqs_pkg::RESET_BYTE_QUANTUM};
         for (int i = 0; i < NUM_QUEUES; i++) begin
            heads_ff[i]  <= '0;
            counts_ff[i] <= '0;
            credit_ff[i] <= pcqs_pkg::CREDIT_WIDTH'(1500);
         end
         rr_ff    <= '0;
         held_ff  <= '0;
         drops_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= (state_ff == ST_RESP);
         if (csr_write_enable) begin
            unique case (csr_index)
               pcqs_pkg::REG_MODE:          cfg_ff.mode          <= csr_write_data[1:0];
               pcqs_pkg::REG_DEFAULT_QUEUE: cfg_ff.default_queue <= csr_write_data[3:0];
               pcqs_pkg::REG_HOLD_CAPACITY: cfg_ff.hold_capacity <= csr_write_data[10:0];
               pcqs_pkg::REG_QUEUE_LIMIT:   cfg_ff.queue_limit   <= csr_write_data[6:0];
               pcqs_pkg::REG_BYTE_QUANTUM:  cfg_ff.byte_quantum  <= csr_write_data;
               default: ;
            endcase
         end
         unique case (state_ff)
            ST_DEC: begin
               if (!kind_ff) begin
                  if (st_we) begin
                     counts_ff[pick_q] <= counts_ff[pick_q] + 1'b1;
                     held_ff <= held_ff + 1'b1;
                  end else if (drops_ff != 16'hFFFF) begin
                     drops_ff <= drops_ff + 1'b1;
                  end
               end
            end
            ST_SCAN: begin
               if (32'(scan_ff) != NUM_QUEUES && counts_ff[rr_ff] == '0) begin
                  credit_ff[rr_ff] <= $signed({1'b0, cfg_ff.byte_quantum});
                  rr_ff <= (32'(rr_ff) == NUM_QUEUES - 1) ? '0 : rr_ff + 1'b1;
               end
            end
            ST_POP: begin
               heads_ff[q_ff]  <= heads_ff[q_ff] + 1'b1;
               counts_ff[q_ff] <= counts_ff[q_ff] - 1'b1;
               held_ff <= held_ff - 1'b1;
               if (cfg_ff.mode == pcqs_pkg::MODE_ROUND) begin
                  if (new_credit <= 0) begin
                     credit_ff[q_ff] <= $signed({1'b0, cfg_ff.byte_quantum});
                     rr_ff <= (32'(q_ff) == NUM_QUEUES - 1) ? '0 : q_ff + 1'b1;
                  end else begin
                     credit_ff[q_ff] <= new_credit;
                  end
               end
            end
            default: ;
         endcase
      end
   end

   // Payload registers of the request and result.
   always_ff @(posedge clock) begin
      unique case (state_ff)
         ST_IDLE: begin
            kind_ff <= req_kind;
            cls_ff  <= req_class_match;
            len_ff  <= req_pkt_len;
            tag_ff  <= req_pkt_tag;
         end
         ST_DEC: begin
            otag_ff <= '0;
            olen_ff <= '0;
            scan_ff <= '0;
            if (!kind_ff) begin
               q_ff      <= pick_q;
               status_ff <= st_we ? pcqs_pkg::STATUS_QUEUED : pcqs_pkg::STATUS_DROPPED;
            end else begin
               q_ff      <= (cfg_ff.mode == pcqs_pkg::MODE_PRIORITY) ? QW'(prio_q) : '0;
               status_ff <= pcqs_pkg::STATUS_EMPTY;
            end
         end
         ST_SCAN: begin
            q_ff    <= rr_ff;
            scan_ff <= scan_ff + 1'b1;
            if (32'(scan_ff) == NUM_QUEUES) q_ff <= '0;
         end
         ST_POP: begin
            otag_ff   <= st_rd[15:0];
            olen_ff   <= st_rd[29:16];
            status_ff <= pcqs_pkg::STATUS_DEQUEUED;
         end
         default: ;
      endcase
   end

   assign busy           = (state_ff != ST_IDLE);
   assign rsp_valid      = valid_ff;
   assign rsp_status     = status_ff;
   assign rsp_out_tag    = otag_ff;
   assign rsp_out_len    = olen_ff;
   assign rsp_out_queue  = 4'(q_ff);
   assign rsp_held_count = held_ff;
   assign rsp_drop_count = drops_ff;

`ifndef SYNTH
   a_held_cap: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DEC && !kind_ff && st_we) |=> held_ff == $past(held_ff) + 11'd1)
      else $error("held count did not rise on a queued request");
   a_one_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result shown on two cycles in a row");
   a_busy_result: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RESP) |=> (rsp_valid && !busy))
      else $error("result not shown on leaving the response state");
`endif

endmodule

// ----- sim/tb_priority_custom_queue_scheduler.sv -----
// Self-checking testbench for the priority and custom queue scheduler.
`timescale 1ns / 1ps

module tb_priority_custom_queue_scheduler;

   localparam logic KIND_ENQUEUE = 1'b0;
   localparam logic KIND_DEQUEUE = 1'b1;
   localparam logic [1:0] MODE_UNUSED = 2'd3;
   localparam int NQ = pcqs_pkg::NUM_QUEUES_DEFAULT;
   localparam int QD = pcqs_pkg::QUEUE_DEPTH_DEFAULT;
   localparam int STALL_LIMIT = 20000;

   typedef struct packed {
      logic        kind;
      logic [4:0]  class_match;
      logic [13:0] pkt_len;
      logic [15:0] pkt_tag;
   } request_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [15:0] out_tag;
      logic [13:0] out_len;
      logic [3:0]  out_queue;
      logic [10:0] held_count;
      logic [15:0] drop_count;
   } result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic req_kind = 1'b0;
   logic [4:0] req_class_match = '0;
   logic [13:0] req_pkt_len = '0;
   logic [15:0] req_pkt_tag = '0;
   logic rsp_valid;
   logic [1:0] rsp_status;
   logic [15:0] rsp_out_tag;
   logic [13:0] rsp_out_len;
   logic [3:0] rsp_out_queue;
   logic [10:0] rsp_held_count;
   logic [15:0] rsp_drop_count;
   logic csr_write_enable = 1'b0;
   logic [2:0] csr_index = '0;
   logic [15:0] csr_write_data = '0;

   priority_custom_queue_scheduler dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_kind(req_kind), .req_class_match(req_class_match),
      .req_pkt_len(req_pkt_len), .req_pkt_tag(req_pkt_tag),
      .rsp_valid(rsp_valid), .rsp_status(rsp_status), .rsp_out_tag(rsp_out_tag),
      .rsp_out_len(rsp_out_len), .rsp_out_queue(rsp_out_queue),
      .rsp_held_count(rsp_held_count), .rsp_drop_count(rsp_drop_count),
      .csr_write_enable(csr_write_enable), .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   always begin
      clock = 1'b1;
      #1;
      clock = 1'b0;
      #1;
   end

   // Requests waiting to be driven, and results predicted for accepted requests.
   request_type pending_requests[$];
   result_type  expected_results[$];
   request_type current_request;
   int sender_idle_pct = 0;
   int mismatch_count = 0;
   int stall_cycles = 0;

   // Scheduler state mirrored by the predictor.
   logic [29:0] packet_words[NQ][QD];
   logic [5:0]  head_slot[NQ];
   logic [6:0]  queue_fill[NQ];
   int          byte_credit[NQ];
   logic [3:0]  rr_turn;
   logic [10:0] packets_held;
   logic [15:0] drop_total;

   pcqs_pkg::cfg_type cfg;

   // Works out the answer to one request and advances the mirrored state.
   function automatic result_type schedule_request(request_type r);
      result_type res;
      int q, limit;
      logic found;
      logic [29:0] word;
      res = '0;
      res.status = pcqs_pkg::STATUS_EMPTY;
      if (r.kind == KIND_ENQUEUE) begin
         if (cfg.mode == pcqs_pkg::MODE_PRIORITY) begin
            q = (r.class_match < pcqs_pkg::PRIORITY_QUEUES) ? int'(r.class_match) :
                int'(cfg.default_queue % 4);
         end else if (cfg.mode == pcqs_pkg::MODE_ROUND) begin
            q = (r.class_match < NQ) ? int'(r.class_match) : int'(cfg.default_queue % NQ);
         end else begin
            q = 0;
         end
         // The per-queue limit applies only to the multi-queue disciplines.
         if (cfg.mode == pcqs_pkg::MODE_PRIORITY || cfg.mode == pcqs_pkg::MODE_ROUND) begin
            limit = (cfg.queue_limit > QD) ? QD : int'(cfg.queue_limit);
         end else begin
            limit = QD;
         end
         res.out_queue = 4'(q);
         if (packets_held < cfg.hold_capacity && queue_fill[q] < limit) begin
            packet_words[q][(head_slot[q] + queue_fill[q]) % QD] = {r.pkt_len, r.pkt_tag};
            queue_fill[q]++;
            packets_held++;
            res.status = pcqs_pkg::STATUS_QUEUED;
         end else begin
            if (drop_total != 16'hFFFF) begin
               drop_total++;
            end
            res.status = pcqs_pkg::STATUS_DROPPED;
         end
      end else if (packets_held != 0) begin
         found = 1'b0;
         q = 0;
         if (cfg.mode == pcqs_pkg::MODE_PRIORITY) begin
            for (int i = 0; i < pcqs_pkg::PRIORITY_QUEUES; i++) begin
               if (!found && queue_fill[i] != 0) begin
                  q = i;
                  found = 1'b1;
               end
            end
         end else if (cfg.mode == pcqs_pkg::MODE_ROUND) begin
            // Empty queues passed over get a fresh credit and the turn moves on.
            for (int i = 0; i < NQ; i++) begin
               if (!found) begin
                  if (queue_fill[rr_turn] != 0) begin
                     q = int'(rr_turn);
                     found = 1'b1;
                  end else begin
                     byte_credit[rr_turn] = int'(cfg.byte_quantum);
                     rr_turn++;
                  end
               end
            end
         end else if (queue_fill[0] != 0) begin
            found = 1'b1;
         end
         if (found) begin
            word = packet_words[q][head_slot[q]];
            head_slot[q]++;
            queue_fill[q]--;
            packets_held--;
            res.out_tag = word[15:0];
            res.out_len = word[29:16];
            res.out_queue = 4'(q);
            res.status = pcqs_pkg::STATUS_DEQUEUED;
            if (cfg.mode == pcqs_pkg::MODE_ROUND) begin
               byte_credit[q] -= int'(word[29:16]);
               if (byte_credit[q] <= 0) begin
                  byte_credit[q] = int'(cfg.byte_quantum);
                  rr_turn = 4'(q + 1);
               end
            end
         end
      end
      res.held_count = packets_held;
      res.drop_count = drop_total;
      return res;
   endfunction

   // Driver: records each accepted request and presents the next one.
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            expected_results = {expected_results, schedule_request(current_request)};
         end
         if (!start || !busy) begin
            if (pending_requests.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
               current_request = pending_requests.pop_front();
               req_kind <= current_request.kind;
               req_class_match <= current_request.class_match;
               req_pkt_len <= current_request.pkt_len;
               req_pkt_tag <= current_request.pkt_tag;
               start <= 1'b1;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // Monitor: every strobed result must match the oldest prediction.
   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_valid) begin
         if (expected_results.size() == 0) begin
            $display("%0t: result with none expected, status %0d", $time, rsp_status);
            mismatch_count++;
         end else begin
            want = expected_results.pop_front();
            if (rsp_status !== want.status) begin
               $display("%0t: status expected %0d actual %0d", $time, want.status, rsp_status);
               mismatch_count++;
            end
            if (rsp_out_tag !== want.out_tag) begin
               $display("%0t: out_tag expected %h actual %h", $time, want.out_tag, rsp_out_tag);
               mismatch_count++;
            end
            if (rsp_out_len !== want.out_len) begin
               $display("%0t: out_len expected %0d actual %0d", $time, want.out_len, rsp_out_len);
               mismatch_count++;
            end
            if (rsp_out_queue !== want.out_queue) begin
               $display("%0t: out_queue expected %0d actual %0d", $time, want.out_queue,
                        rsp_out_queue);
               mismatch_count++;
            end
            if (rsp_held_count !== want.held_count) begin
               $display("%0t: held_count expected %0d actual %0d", $time, want.held_count,
                        rsp_held_count);
               mismatch_count++;
            end
            if (rsp_drop_count !== want.drop_count) begin
               $display("%0t: drop_count expected %0d actual %0d", $time, want.drop_count,
                        rsp_drop_count);
               mismatch_count++;
            end
         end
      end
   end

   // Watchdog: a long run of cycles with no handshake at all means a hang.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   // Writes one register while the block is idle and mirrors it.
   task automatic write_register(input logic [2:0] index, input logic [15:0] value);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= index;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      case (index)
         pcqs_pkg::REG_MODE:          cfg.mode = value[1:0];
         pcqs_pkg::REG_DEFAULT_QUEUE: cfg.default_queue = value[3:0];
         pcqs_pkg::REG_HOLD_CAPACITY: cfg.hold_capacity = value[10:0];
         pcqs_pkg::REG_QUEUE_LIMIT:   cfg.queue_limit = value[6:0];
         pcqs_pkg::REG_BYTE_QUANTUM:  cfg.byte_quantum = value;
         default: ;
      endcase
   endtask

   task automatic apply_settings(input logic [1:0] mode, input logic [3:0] dflt,
                                 input logic [10:0] cap, input logic [6:0] qlim,
                                 input logic [15:0] quantum);
      write_register(pcqs_pkg::REG_MODE, 16'(mode));
      write_register(pcqs_pkg::REG_DEFAULT_QUEUE, 16'(dflt));
      write_register(pcqs_pkg::REG_HOLD_CAPACITY, 16'(cap));
      write_register(pcqs_pkg::REG_QUEUE_LIMIT, 16'(qlim));
      write_register(pcqs_pkg::REG_BYTE_QUANTUM, quantum);
   endtask

   // Holds the sender back until every outstanding result has come back.
   task automatic wait_for_idle();
      while (pending_requests.size() != 0 || expected_results.size() != 0 || start) begin
         @(posedge clock);
      end
      repeat (25) @(posedge clock);
   endtask

   task automatic queue_request(input logic kind, input logic [4:0] cls,
                                input logic [13:0] len, input logic [15:0] tag);
      request_type r;
      r.kind = kind;
      r.class_match = cls;
      r.pkt_len = len;
      r.pkt_tag = tag;
      pending_requests = {pending_requests, r};
   endtask

   // Random traffic in bursts so queues both fill to their limits and drain.
   task automatic random_traffic(input int count, input int enqueue_pct, input int idle_pct);
      int burst_left;
      int burst_pct;
      logic [13:0] len;
      logic [4:0] cls;
      burst_left = 0;
      burst_pct = enqueue_pct;
      sender_idle_pct = idle_pct;
      for (int n = 0; n < count; n++) begin
         if (burst_left == 0) begin
            burst_left = $urandom_range(5, 40);
            burst_pct = ($urandom_range(2) == 0) ? 100 - enqueue_pct : enqueue_pct;
         end
         burst_left--;
         case ($urandom_range(9))
            0: len = 14'd0;
            1: len = 14'h3FFF;
            2, 3, 4, 5: len = 14'($urandom_range(0, 3000));
            default: len = 14'($urandom);
         endcase
         cls = ($urandom_range(5) == 0) ? 5'($urandom_range(16, 31)) : 5'($urandom_range(0, 15));
         queue_request(($urandom_range(99) < burst_pct) ? KIND_ENQUEUE : KIND_DEQUEUE,
                       cls, len, 16'($urandom));
      end
      wait_for_idle();
   endtask

   initial begin
      foreach (head_slot[i]) begin
         head_slot[i] = '0;
         queue_fill[i] = '0;
         byte_credit[i] = int'(pcqs_pkg::RESET_BYTE_QUANTUM);
      end
      rr_turn = '0;
      packets_held = '0;
      drop_total = '0;
      cfg.mode = pcqs_pkg::RESET_MODE;
      cfg.default_queue = pcqs_pkg::RESET_DEFAULT_QUEUE;
      cfg.hold_capacity = pcqs_pkg::RESET_HOLD_CAPACITY;
      cfg.queue_limit = pcqs_pkg::RESET_QUEUE_LIMIT;
      cfg.byte_quantum = pcqs_pkg::RESET_BYTE_QUANTUM;

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      repeat (2) @(posedge clock);

      // Directed part under reset settings: empty dequeues, field extremes,
      // class values that match nothing, and a drain back to empty.
      queue_request(KIND_DEQUEUE, 5'd0, 14'd0, 16'd0);
      queue_request(KIND_ENQUEUE, 5'd0, 14'd0, 16'd0);
      queue_request(KIND_ENQUEUE, 5'd31, 14'h3FFF, 16'hFFFF);
      queue_request(KIND_ENQUEUE, 5'd16, 14'h2AAA, 16'h5555);
      queue_request(KIND_ENQUEUE, 5'd15, 14'h1555, 16'hAAAA);
      for (int i = 0; i < 5; i++) begin
         queue_request(KIND_DEQUEUE, 5'($urandom), 14'($urandom), 16'($urandom));
      end
      wait_for_idle();

      // Strict priority with roomy limits, the default queue folded modulo four.
      apply_settings(pcqs_pkg::MODE_PRIORITY, 4'd7, 11'd1024, 7'd64, 16'd1500);
      queue_request(KIND_ENQUEUE, 5'd3, 14'd100, 16'h0003);
      queue_request(KIND_ENQUEUE, 5'd20, 14'd200, 16'h0020);
      queue_request(KIND_ENQUEUE, 5'd0, 14'd300, 16'h0000);
      queue_request(KIND_ENQUEUE, 5'd5, 14'd400, 16'h0005);
      for (int i = 0; i < 5; i++) begin
         queue_request(KIND_DEQUEUE, 5'd0, 14'd0, 16'd0);
      end
      wait_for_idle();
      random_traffic(200, 60, 0);

      // Round robin with the smallest non-zero quantum and a tight total capacity.
      apply_settings(pcqs_pkg::MODE_ROUND, 4'd15, 11'd75, 7'd20, 16'd1);
      random_traffic(200, 60, 46);

      // Round robin with the largest quantum and the largest queue limit,
      // which saturates to the queue depth.
      apply_settings(pcqs_pkg::MODE_ROUND, 4'd9, 11'd1024, 7'd127, 16'd65535);
      random_traffic(220, 70, 34);

      // Zero quantum and zero capacity and limit: everything offered drops.
      apply_settings(pcqs_pkg::MODE_ROUND, 4'd2, 11'd0, 7'd0, 16'd0);
      random_traffic(60, 60, 0);

      // Zero quantum moves the turn after every packet.
      apply_settings(pcqs_pkg::MODE_ROUND, 4'd2, 11'd1024, 7'd1, 16'd0);
      random_traffic(150, 55, 46);

      // Leave packets in the upper queues, then serve with strict priority so
      // they stay held as stale entries.
      apply_settings(pcqs_pkg::MODE_ROUND, 4'd12, 11'd1024, 7'd64, 16'd3000);
      random_traffic(100, 85, 0);
      apply_settings(pcqs_pkg::MODE_PRIORITY, 4'd14, 11'd1024, 7'd64, 16'd3000);
      random_traffic(120, 45, 34);

      // The unused mode acts as a single FIFO; then a small total capacity.
      apply_settings(MODE_UNUSED, 4'd0, 11'd1024, 7'd64, 16'd1500);
      random_traffic(150, 50, 46);
      apply_settings(pcqs_pkg::MODE_FIFO, 4'd0, 11'd10, 7'd20, 16'd1500);
      random_traffic(100, 60, 0);

      // Back to round robin to drain what the other modes left behind.
      apply_settings(pcqs_pkg::MODE_ROUND, 4'd0, 11'd1024, 7'd64, 16'd1500);
      random_traffic(100, 20, 34);

      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
